FILE: rtl/core/dpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpss_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REACHED_WAIT = 2'd3;

    localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd1000;
    localparam logic [7:0]  TOGGLE_DELAY_RESET = 8'd2;
    localparam logic [15:0] ACK_WAIT_RESET     = 16'd2000;
    localparam logic [15:0] REACHED_WAIT_RESET = 16'd5000;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ON   = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;
    localparam logic [1:0] OP_MOVE = 2'd3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;
    localparam logic [1:0] MODE_MOVE = 2'd3;

    localparam logic [2:0] PH_NONE  = 3'd0;
    localparam logic [2:0] PH_CLEAR = 3'd1;
    localparam logic [2:0] PH_DELAY = 3'd2;
    localparam logic [2:0] PH_ACK   = 3'd3;
    localparam logic [2:0] PH_REACH = 3'd4;

    localparam logic [2:0] PS_DISABLED = 3'd0;
    localparam logic [2:0] PS_READY    = 3'd1;
    localparam logic [2:0] PS_SWON     = 3'd2;
    localparam logic [2:0] PS_ENABLED  = 3'd3;
    localparam logic [2:0] PS_FAULT    = 3'd4;
    localparam logic [2:0] PS_UNKNOWN  = 3'd5;

    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_OK      = 2'd1;
    localparam logic [1:0] FIN_TIMEOUT = 2'd2;

    localparam logic [15:0] SW_MASK_SHORT = 16'h004F;
    localparam logic [15:0] SW_MASK_LONG  = 16'h006F;
    localparam logic [15:0] SW_DISABLED   = 16'h0040;
    localparam logic [15:0] SW_READY      = 16'h0021;
    localparam logic [15:0] SW_SWON       = 16'h0023;
    localparam logic [15:0] SW_ENABLED    = 16'h0027;
    localparam logic [15:0] SW_FAULT      = 16'h0008;
    localparam logic [15:0] SW_REACHED    = 16'h0400;
    localparam logic [15:0] SW_ACK        = 16'h1000;

    localparam logic [15:0] CW_ZERO       = 16'h0000;
    localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON  = 16'h0007;
    localparam logic [15:0] CW_ENABLE     = 16'h000F;
    localparam logic [15:0] CW_FAULT_RST  = 16'h0080;
    localparam logic [15:0] CW_NEWSP      = 16'h0010;
    localparam logic [15:0] CW_REL        = 16'h0040;

    typedef struct packed {
        logic [15:0] clear_wait_limit;
        logic [7:0]  toggle_delay;
        logic [15:0] ack_wait_limit;
        logic [15:0] reached_wait_limit;
    } dpss_cfg_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         phase;
        logic [15:0]        cnt;
        logic [15:0]        ctl;
        logic signed [31:0] tgt;
    } dpss_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpss_step.sv
`timescale 1ns / 1ps
`default_nettype none

module dpss_step (
    input  dpss_pkg::dpss_cfg_t   cfg,
    input  dpss_pkg::dpss_state_t cur,
    input  logic [1:0]            opcode,
    input  logic [15:0]           status_word,
    input  logic signed [31:0]    move_target,
    output dpss_pkg::dpss_state_t nxt,
    output logic [2:0]            power_state,
    output logic [1:0]            finish_code
);
    import dpss_pkg::*;

    logic [15:0] sw_short;
    logic [15:0] sw_long;

    assign sw_short = status_word & SW_MASK_SHORT;
    assign sw_long  = status_word & SW_MASK_LONG;

    always_comb
    begin
        priority if (sw_short == SW_DISABLED)
            power_state = PS_DISABLED;
        else if (sw_long == SW_READY)
            power_state = PS_READY;
        else if (sw_long == SW_SWON)
            power_state = PS_SWON;
        else if (sw_long == SW_ENABLED)
            power_state = PS_ENABLED;
        else if (sw_short == SW_FAULT)
            power_state = PS_FAULT;
        else
            power_state = PS_UNKNOWN;
    end

    always_comb
    begin
        dpss_state_t s;
        logic        do_reach;
        logic        reached;
        logic [15:0] cnt_inc;

        s        = cur;
        do_reach = 1'b0;
        reached  = (status_word & SW_REACHED) != CW_ZERO;
        finish_code = FIN_NONE;

        if (cur.mode == MODE_IDLE && opcode != OP_TICK)
        begin
            s.mode = opcode;
            if (opcode == OP_MOVE)
            begin
                s.tgt   = move_target;
                s.phase = PH_CLEAR;
                s.cnt   = 16'd0;
            end
        end

        cnt_inc = s.cnt + 16'd1;

        unique case (s.mode)
            MODE_IDLE:
            begin
            end
            MODE_ON:
            begin
                if (power_state == PS_ENABLED)
                begin
                    s.mode      = MODE_IDLE;
                    finish_code = FIN_OK;
                end
                else
                begin
                    unique case (power_state)
                        PS_READY: s.ctl = CW_SWITCH_ON;
                        PS_SWON:  s.ctl = CW_ENABLE;
                        PS_FAULT: s.ctl = CW_FAULT_RST;
                        default:  s.ctl = CW_SHUTDOWN;
                    endcase
                end
            end
            MODE_OFF:
            begin
                if (power_state == PS_DISABLED)
                begin
                    s.mode      = MODE_IDLE;
                    finish_code = FIN_OK;
                end
                else
                begin
                    unique case (power_state)
                        PS_ENABLED: s.ctl = CW_SWITCH_ON;
                        PS_SWON:    s.ctl = CW_SHUTDOWN;
                        PS_FAULT:   s.ctl = CW_FAULT_RST;
                        default:    s.ctl = CW_ZERO;
                    endcase
                end
            end
            MODE_MOVE:
            begin
                unique case (s.phase)
                    PH_CLEAR:
                    begin
                        if (s.cnt >= cfg.clear_wait_limit || !reached)
                        begin
                            s.ctl = (s.ctl | CW_ENABLE) & ~(CW_REL | CW_NEWSP);
                            s.cnt = 16'd0;
                            if (cfg.toggle_delay == 8'd0)
                            begin
                                s.ctl   = s.ctl | CW_NEWSP;
                                s.phase = PH_ACK;
                            end
                            else
                                s.phase = PH_DELAY;
                        end
                        else
                            s.cnt = cnt_inc;
                    end
                    PH_DELAY:
                    begin
                        if (cnt_inc >= {8'd0, cfg.toggle_delay})
                        begin
                            s.ctl   = s.ctl | CW_NEWSP;
                            s.phase = PH_ACK;
                            s.cnt   = 16'd0;
                        end
                        else
                            s.cnt = cnt_inc;
                    end
                    PH_ACK:
                    begin
                        if (s.cnt >= cfg.ack_wait_limit
                            || (status_word & SW_ACK) != CW_ZERO)
                        begin
                            s.phase  = PH_REACH;
                            s.cnt    = 16'd0;
                            do_reach = 1'b1;
                        end
                        else
                            s.cnt = cnt_inc;
                    end
                    PH_REACH:
                        do_reach = 1'b1;
                    default:
                    begin
                        s.ctl   = s.ctl & ~CW_NEWSP;
                        s.mode  = MODE_IDLE;
                        s.phase = PH_NONE;
                        s.cnt   = 16'd0;
                    end
                endcase

                if (do_reach)
                begin
                    if (s.cnt >= cfg.reached_wait_limit || reached)
                    begin
                        finish_code = (s.cnt >= cfg.reached_wait_limit)
                                      ? FIN_TIMEOUT : FIN_OK;
                        s.ctl   = s.ctl & ~CW_NEWSP;
                        s.mode  = MODE_IDLE;
                        s.phase = PH_NONE;
                        s.cnt   = 16'd0;
                    end
                    else
                        s.cnt = s.cnt + 16'd1;
                end
            end
        endcase

        nxt = s;
    end

endmodule

`default_nettype wire

FILE: rtl/core/drive_power_state_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   opcode, status_word, move_target
// out      output     out_valid/out_stall control_word, target_out, power_state,
//                                         busy_res, finish_code
// cfg      input      cfg_we              cfg_index, cfg_data
//
// One item per cycle while out_stall is low; an item passes the input register
// then the result register, with the sequencer step between them.
// The sequencer state advances when an item moves from the input register
// into the result register.
// Reset clears the sequencer state, both valid flags and loads the default
// wait limits. An out_stall holds the result and backs up into in_stall.

module drive_power_state_sequencer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     opcode,
    input  wire logic [15:0]                    status_word,
    input  wire logic signed [31:0]             move_target,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [15:0]                         control_word,
    output logic signed [31:0]                  target_out,
    output logic [2:0]                          power_state,
    output logic                                busy_res,
    output logic [1:0]                          finish_code,
    input  wire logic                           cfg_we,
    input  wire logic [dpss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dpss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dpss_pkg::*;

    dpss_cfg_t          cfg_reg;
    dpss_state_t        state_reg;
    dpss_state_t        state_next;

    logic               in_valid_reg;
    logic [1:0]         opcode_reg;
    logic [15:0]        status_reg;
    logic signed [31:0] target_reg;

    logic               out_valid_reg;
    logic [15:0]        control_word_reg;
    logic signed [31:0] target_out_reg;
    logic [2:0]         power_state_reg;
    logic               busy_res_reg;
    logic [1:0]         finish_code_reg;

    logic               out_free;
    logic               advance;
    logic [2:0]         ps_next;
    logic [1:0]         fin_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    dpss_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .opcode      (opcode_reg),
        .status_word (status_reg),
        .move_target (target_reg),
        .nxt         (state_next),
        .power_state (ps_next),
        .finish_code (fin_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clear_wait_limit   <= CLEAR_WAIT_RESET;
            cfg_reg.toggle_delay       <= TOGGLE_DELAY_RESET;
            cfg_reg.ack_wait_limit     <= ACK_WAIT_RESET;
            cfg_reg.reached_wait_limit <= REACHED_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLEAR_WAIT:   cfg_reg.clear_wait_limit   <= cfg_data;
                CFG_TOGGLE_DELAY: cfg_reg.toggle_delay       <= cfg_data[7:0];
                CFG_ACK_WAIT:     cfg_reg.ack_wait_limit     <= cfg_data;
                CFG_REACHED_WAIT: cfg_reg.reached_wait_limit <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            opcode_reg <= opcode;
            status_reg <= status_word;
            target_reg <= move_target;
        end
        if (advance)
        begin
            control_word_reg <= state_next.ctl;
            target_out_reg   <= state_next.tgt;
            power_state_reg  <= ps_next;
            busy_res_reg     <= state_next.mode != MODE_IDLE;
            finish_code_reg  <= fin_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign control_word = control_word_reg;
    assign target_out   = target_out_reg;
    assign power_state  = power_state_reg;
    assign busy_res     = busy_res_reg;
    assign finish_code  = finish_code_reg;

`ifndef ASSERT_OFF
    a_phase_only_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_NONE |-> state_reg.mode == MODE_MOVE)
        else $error("move phase set outside move mode");

    a_finish_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && finish_code_reg != FIN_NONE |-> !busy_res_reg)
        else $error("finished result still busy");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with room downstream");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without an item");
`endif

endmodule

`default_nettype wire
